// ===== rtl/dlfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfs_pkg
// Shared types, codes and helpers of the debounced line-follow steering block.
// ----------------------------------------------------------------------------
package dlfs_pkg;

  localparam int unsigned DEB_W     = 4;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned SENSOR_W  = 2;
  localparam int unsigned DIRS_W    = 4;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
  localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;

  localparam logic [DIRS_W-1:0] DIRS_STOP     = 4'h0;
  localparam logic [DIRS_W-1:0] DIRS_STRAIGHT = 4'h5;
  localparam logic [DIRS_W-1:0] DIRS_LEFT     = 4'h6;
  localparam logic [DIRS_W-1:0] DIRS_RIGHT    = 4'h9;

  // sensor patterns, bit0 left, bit1 right
  localparam logic [SENSOR_W-1:0] SNS_NONE  = 2'h0;
  localparam logic [SENSOR_W-1:0] SNS_LEFT  = 2'h1;
  localparam logic [SENSOR_W-1:0] SNS_RIGHT = 2'h2;
  localparam logic [SENSOR_W-1:0] SNS_BOTH  = 2'h3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_FWD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_REV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP   = 3'd4;

  localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 4'd3;
  localparam logic [DUTY_W-1:0] RST_BASE     = 7'd24;
  localparam logic [DUTY_W-1:0] RST_TURN_FWD = 7'd40;
  localparam logic [DUTY_W-1:0] RST_TURN_REV = 7'd16;
  localparam logic [TICK_W-1:0] RST_STARTUP  = 16'd500;

  typedef enum logic [ACT_W-1:0] {
    ACT_STRAIGHT = 2'd0,
    ACT_LEFT     = 2'd1,
    ACT_RIGHT    = 2'd2
  } act_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [DUTY_W-1:0] base_speed;
    logic [DUTY_W-1:0] turn_forward_speed;
    logic [DUTY_W-1:0] turn_reverse_speed;
    logic [TICK_W-1:0] startup_window;
  } cfg_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] prev_sample;
    logic [DEB_W-1:0]    stable_run;
    logic [TICK_W-1:0]   elapsed_ticks;
    logic [DIRS_W-1:0]   drive_dirs;
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
    logic                station_flag;
    act_t                steer_action;
  } state_t;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

endpackage

// ===== rtl/dlfs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfs_in_if
// Sensor tick channel: valid/ready with the two line-sensor bits.
// ----------------------------------------------------------------------------
interface dlfs_in_if;
  logic                              valid;
  logic                              ready;
  logic [dlfs_pkg::SENSOR_W-1:0]     sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

// ===== rtl/dlfs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfs_out_if
// Drive result channel: valid/ready with bridge directions, duties and status.
// ----------------------------------------------------------------------------
interface dlfs_out_if;
  logic                            valid;
  logic                            ready;
  logic [dlfs_pkg::DIRS_W-1:0]     bridge_dirs;
  logic [dlfs_pkg::DUTY_W-1:0]     duty_left;
  logic [dlfs_pkg::DUTY_W-1:0]     duty_right;
  logic                            station_detected;
  logic [dlfs_pkg::ACT_W-1:0]      last_action;
  logic                            applied;

  modport source (output valid, output bridge_dirs, output duty_left, output duty_right,
                  output station_detected, output last_action, output applied,
                  input ready);
  modport sink   (input valid, input bridge_dirs, input duty_left, input duty_right,
                  input station_detected, input last_action, input applied,
                  output ready);
endinterface

// ===== rtl/dlfs_steer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfs_steer
// Next-state logic for one tick: debounce, start-up window and steering decode.
// ----------------------------------------------------------------------------
module dlfs_steer (
  input  logic [dlfs_pkg::SENSOR_W-1:0] sample,
  input  dlfs_pkg::cfg_t                cfg,
  input  dlfs_pkg::state_t              cur,
  output dlfs_pkg::state_t              nxt,
  output logic                          apply
);

  logic [dlfs_pkg::DUTY_W-1:0] base_sat;
  logic [dlfs_pkg::DUTY_W-1:0] fwd_sat;
  logic [dlfs_pkg::DUTY_W-1:0] rev_sat;

  assign base_sat = dlfs_pkg::sat_duty(cfg.base_speed);
  assign fwd_sat  = dlfs_pkg::sat_duty(cfg.turn_forward_speed);
  assign rev_sat  = dlfs_pkg::sat_duty(cfg.turn_reverse_speed);

  always_comb begin
    nxt   = cur;
    apply = 1'b0;

    if (cur.elapsed_ticks != dlfs_pkg::TICK_MAX) begin
      nxt.elapsed_ticks = cur.elapsed_ticks + 16'd1;
    end

    if (sample != cur.prev_sample) begin
      nxt.prev_sample = sample;
      nxt.stable_run  = 4'd1;
    end else begin
      if (cur.stable_run < cfg.debounce_ticks) begin
        nxt.stable_run = cur.stable_run + 4'd1;
      end
      apply = (nxt.stable_run >= cfg.debounce_ticks);
    end

    if (apply) begin
      nxt.station_flag = 1'b0;
      unique case (sample)
        dlfs_pkg::SNS_NONE: begin
          nxt.drive_dirs   = dlfs_pkg::DIRS_STRAIGHT;
          nxt.left_duty    = base_sat;
          nxt.right_duty   = base_sat;
          nxt.steer_action = dlfs_pkg::ACT_STRAIGHT;
        end
        dlfs_pkg::SNS_RIGHT: begin
          nxt.drive_dirs   = dlfs_pkg::DIRS_LEFT;
          nxt.left_duty    = rev_sat;
          nxt.right_duty   = fwd_sat;
          nxt.steer_action = dlfs_pkg::ACT_LEFT;
        end
        dlfs_pkg::SNS_LEFT: begin
          nxt.drive_dirs   = dlfs_pkg::DIRS_RIGHT;
          nxt.left_duty    = fwd_sat;
          nxt.right_duty   = rev_sat;
          nxt.steer_action = dlfs_pkg::ACT_RIGHT;
        end
        dlfs_pkg::SNS_BOTH: begin
          if (nxt.elapsed_ticks < cfg.startup_window) begin
            nxt.drive_dirs   = dlfs_pkg::DIRS_STRAIGHT;
            nxt.left_duty    = base_sat;
            nxt.right_duty   = base_sat;
            nxt.steer_action = dlfs_pkg::ACT_STRAIGHT;
          end else begin
            // stop on station, keep last action
            nxt.drive_dirs   = dlfs_pkg::DIRS_STOP;
            nxt.left_duty    = '0;
            nxt.right_duty   = '0;
            nxt.station_flag = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/debounced_line_follow_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_line_follow_steering
// Two-sensor line follower with debounced sampling, start-up window and
// station stop; one drive result per sensor tick.
//
//   channel  | direction | beat contents
//   ---------+-----------+--------------------------------------------------
//   in_ch    | sink      | sensor_bits
//   out_ch   | source    | bridge_dirs, duty_left, duty_right,
//            |           | station_detected, last_action, applied
//   cfg_*    | write     | cfg_we, cfg_index, cfg_data
//
// One tick per cycle while the output is not stalled: a beat accepted at an edge
// is decoded in the same cycle and its result sits in the output register from
// the next cycle on. Throughput is one beat per cycle, set by the single output
// register that in_ch.ready tracks (ready while it is empty or taken).
// A stalled output holds its beat and stalls the input.
// Synchronous active-low reset restores register defaults and clears state.
// ----------------------------------------------------------------------------
module debounced_line_follow_steering (
  input  logic                             clk,
  input  logic                             rst_n,
  dlfs_in_if.sink                          in_ch,
  dlfs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dlfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlfs_pkg::CFG_DAT_W-1:0]   cfg_data
);

  dlfs_pkg::cfg_t   cfg_r;
  dlfs_pkg::state_t state_r;
  dlfs_pkg::state_t state_nxt;
  logic             apply_nxt;
  logic             out_valid_r;
  logic             applied_r;
  logic             in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  dlfs_steer u_steer (
    .sample (in_ch.sensor_bits),
    .cfg    (cfg_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .apply  (apply_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks       <= dlfs_pkg::RST_DEBOUNCE;
      cfg_r.base_speed           <= dlfs_pkg::RST_BASE;
      cfg_r.turn_forward_speed   <= dlfs_pkg::RST_TURN_FWD;
      cfg_r.turn_reverse_speed   <= dlfs_pkg::RST_TURN_REV;
      cfg_r.startup_window       <= dlfs_pkg::RST_STARTUP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlfs_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_data[dlfs_pkg::DEB_W-1:0];
        dlfs_pkg::CFG_BASE:     cfg_r.base_speed         <= cfg_data[dlfs_pkg::DUTY_W-1:0];
        dlfs_pkg::CFG_TURN_FWD: cfg_r.turn_forward_speed <= cfg_data[dlfs_pkg::DUTY_W-1:0];
        dlfs_pkg::CFG_TURN_REV: cfg_r.turn_reverse_speed <= cfg_data[dlfs_pkg::DUTY_W-1:0];
        dlfs_pkg::CFG_STARTUP:  cfg_r.startup_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      applied_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        applied_r   <= apply_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        // drop the taken beat
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.bridge_dirs      = state_r.drive_dirs;
  assign out_ch.duty_left        = state_r.left_duty;
  assign out_ch.duty_right       = state_r.right_duty;
  assign out_ch.station_detected = state_r.station_flag;
  assign out_ch.last_action      = state_r.steer_action;
  assign out_ch.applied          = applied_r;

`ifndef SYNTH
  a_acc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat left no result");

  a_station_stops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.station_flag |-> (state_r.drive_dirs == dlfs_pkg::DIRS_STOP &&
                              state_r.left_duty == '0 && state_r.right_duty == '0))
    else $error("station flag with motors running");

  a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> state_r.elapsed_ticks >= $past(state_r.elapsed_ticks))
    else $error("elapsed tick counter went back");

  a_hold_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !apply_nxt) |=> ($stable(state_r.drive_dirs) && $stable(state_r.left_duty) &&
                                $stable(state_r.right_duty) && !applied_r))
    else $error("drive changed without an applied sample");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r.left_duty <= dlfs_pkg::DUTY_MAX &&
                     state_r.right_duty <= dlfs_pkg::DUTY_MAX))
    else $error("duty above full scale");
`endif

endmodule

// ===== verif/tb_debounced_line_follow_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_line_follow_steering
// Self-checking bench for the debounced line-follow steering block. A queue of
// sensor ticks feeds a valid/ready driver. A clocked predictor tracks the
// debounce run, the start-up window and the held drive, and a monitor checks
// every drive beat against it. Covered: directed corner ticks, random
// well-formed and broken sample runs under several register settings, random
// gaps on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_debounced_line_follow_steering;
  import dlfs_pkg::*;

  localparam int unsigned MAX_GAP      = 19;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [DIRS_W-1:0] dirs;
    logic [DUTY_W-1:0] duty_l;
    logic [DUTY_W-1:0] duty_r;
    logic              station;
    act_t              action;
    logic              applied;
  } drive_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  dlfs_in_if  in_ch ();
  dlfs_out_if out_ch ();

  debounced_line_follow_steering u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfg_t                shadow_cfg;
  logic [SENSOR_W-1:0] last_sample;
  logic [DEB_W-1:0]    run_len;
  logic [TICK_W-1:0]   tick_count;
  drive_beat_t         drive_now;

  logic [SENSOR_W-1:0] pending_ticks[$];
  drive_beat_t         expected_drive[$];

  bit          idle_on;
  int unsigned holds_req;
  int unsigned holds_done;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned stray_count;
  int unsigned beats_checked;
  int unsigned applied_count;
  int unsigned station_count;
  int unsigned settings_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic set_drive(input logic [DIRS_W-1:0] dirs, input logic [DUTY_W-1:0] l,
                           input logic [DUTY_W-1:0] r, input act_t act);
    drive_now.dirs    = dirs;
    drive_now.duty_l  = (l > DUTY_MAX) ? DUTY_MAX : l;
    drive_now.duty_r  = (r > DUTY_MAX) ? DUTY_MAX : r;
    drive_now.station = 1'b0;
    drive_now.action  = act;
  endtask

  task automatic predict_drive(input logic [SENSOR_W-1:0] s);
    logic take;
    take = 1'b0;
    if (tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
    if (s != last_sample) begin
      last_sample = s;
      run_len     = DEB_W'(1);
    end else begin
      if (run_len < shadow_cfg.debounce_ticks) run_len = run_len + 1'b1;
      take = (run_len >= shadow_cfg.debounce_ticks);
    end
    if (take) begin
      applied_count++;
      case (s)
        SNS_NONE: begin
          set_drive(DIRS_STRAIGHT, shadow_cfg.base_speed, shadow_cfg.base_speed, ACT_STRAIGHT);
        end
        SNS_RIGHT: begin
          set_drive(DIRS_LEFT, shadow_cfg.turn_reverse_speed, shadow_cfg.turn_forward_speed,
                    ACT_LEFT);
        end
        SNS_LEFT: begin
          set_drive(DIRS_RIGHT, shadow_cfg.turn_forward_speed, shadow_cfg.turn_reverse_speed,
                    ACT_RIGHT);
        end
        SNS_BOTH: begin
          if (tick_count < shadow_cfg.startup_window) begin
            set_drive(DIRS_STRAIGHT, shadow_cfg.base_speed, shadow_cfg.base_speed,
                      ACT_STRAIGHT);
          end else begin
            drive_now.dirs    = DIRS_STOP;
            drive_now.duty_l  = '0;
            drive_now.duty_r  = '0;
            drive_now.station = 1'b1;
            station_count++;
          end
        end
      endcase
    end
    drive_now.applied = take;
    expected_drive.push_back(drive_now);
  endtask

  // sender: hold a stalled beat, then sit out the drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap    <= send_gap - 1;
    end else if (pending_ticks.size() != 0) begin
      in_ch.valid       <= 1'b1;
      in_ch.sensor_bits <= pending_ticks.pop_front();
      send_gap          <= idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : recv_side
    int unsigned draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
      holds_done   <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= (hold_left == 1);
      hold_left    <= hold_left - 1;
    end else if (holds_done != holds_req) begin
      out_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      holds_done   <= holds_done + 1;
    end else if (out_ch.valid && out_ch.ready) begin
      draw = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      out_ch.ready <= (draw == 0);
      recv_gap     <= draw;
    end else if (recv_gap != 0) begin
      out_ch.ready <= (recv_gap == 1);
      recv_gap     <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : scoreboard
    drive_beat_t got;
    drive_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.dirs    = out_ch.bridge_dirs;
        got.duty_l  = out_ch.duty_left;
        got.duty_r  = out_ch.duty_right;
        got.station = out_ch.station_detected;
        got.action  = act_t'(out_ch.last_action);
        got.applied = out_ch.applied;
        beats_checked++;
        if (expected_drive.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= REPORT_MAX)
            $display("%0t: drive beat with none expected: dirs=%h l=%0d r=%0d", $realtime,
                     got.dirs, got.duty_l, got.duty_r);
        end else begin
          want = expected_drive.pop_front();
          if (got.dirs !== want.dirs || got.duty_l !== want.duty_l ||
              got.duty_r !== want.duty_r || got.station !== want.station ||
              got.action !== want.action || got.applied !== want.applied) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= REPORT_MAX) begin
              $display("%0t: beat %0d expected dirs=%h l=%0d r=%0d stn=%0b act=%0d app=%0b",
                       $realtime, beats_checked, want.dirs, want.duty_l, want.duty_r,
                       want.station, want.action, want.applied);
              $display("%0t: beat %0d actual   dirs=%h l=%0d r=%0d stn=%0b act=%0d app=%0b",
                       $realtime, beats_checked, got.dirs, got.duty_l, got.duty_r,
                       got.station, got.action, got.applied);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_drive(in_ch.sensor_bits);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_run(input logic [SENSOR_W-1:0] s, input int unsigned len);
    repeat (len) pending_ticks.push_back(s);
  endtask

  // mostly runs long enough to apply, some cut one short, some single glitches
  task automatic random_ticks(input int unsigned n);
    int unsigned         remaining;
    int unsigned         len;
    int unsigned         pick;
    logic [SENSOR_W-1:0] s;
    remaining = n;
    while (remaining != 0) begin
      s    = SENSOR_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick < 7) len = shadow_cfg.debounce_ticks + $urandom_range(0, 3);
      else if (pick < 9) len = (shadow_cfg.debounce_ticks > 1) ? shadow_cfg.debounce_ticks - 1 : 1;
      else len = 1;
      if (len == 0) len = 1;
      if (len > remaining) len = remaining;
      push_run(s, len);
      remaining -= len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || expected_drive.size() != 0 || in_ch.valid);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DEBOUNCE: shadow_cfg.debounce_ticks     = val[DEB_W-1:0];
      CFG_BASE:     shadow_cfg.base_speed         = val[DUTY_W-1:0];
      CFG_TURN_FWD: shadow_cfg.turn_forward_speed = val[DUTY_W-1:0];
      CFG_TURN_REV: shadow_cfg.turn_reverse_speed = val[DUTY_W-1:0];
      CFG_STARTUP:  shadow_cfg.startup_window     = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t c);
    write_reg(CFG_DEBOUNCE, CFG_DAT_W'(c.debounce_ticks));
    write_reg(CFG_BASE, CFG_DAT_W'(c.base_speed));
    write_reg(CFG_TURN_FWD, CFG_DAT_W'(c.turn_forward_speed));
    write_reg(CFG_TURN_REV, CFG_DAT_W'(c.turn_reverse_speed));
    write_reg(CFG_STARTUP, CFG_DAT_W'(c.startup_window));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_count++;
  endtask

  function automatic logic [DUTY_W-1:0] pick_speed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DUTY_MAX;
      2:       return '1;
      default: return DUTY_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    cfg_t        setting;
    int unsigned phase;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sensor_bits = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    idle_on           = 1'b1;
    holds_req         = 0;
    mismatch_count    = 0;
    stray_count       = 0;
    beats_checked     = 0;
    applied_count     = 0;
    station_count     = 0;
    settings_count    = 0;
    shadow_cfg.debounce_ticks     = RST_DEBOUNCE;
    shadow_cfg.base_speed         = RST_BASE;
    shadow_cfg.turn_forward_speed = RST_TURN_FWD;
    shadow_cfg.turn_reverse_speed = RST_TURN_REV;
    shadow_cfg.startup_window     = RST_STARTUP;
    last_sample = '0;
    run_len     = '0;
    tick_count  = '0;
    drive_now   = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every pattern, repeat after apply, station inside the window
    push_run(SNS_NONE, 3);
    push_run(SNS_LEFT, 4);
    push_run(SNS_RIGHT, 3);
    push_run(SNS_BOTH, 3);
    push_run(SNS_LEFT, 1);
    push_run(SNS_RIGHT, 1);
    push_run(SNS_NONE, 1);
    wait_idle();

    // no window, speeds above range and at the ends
    setting.debounce_ticks     = 4'd1;
    setting.base_speed         = '1;
    setting.turn_forward_speed = DUTY_MAX;
    setting.turn_reverse_speed = '0;
    setting.startup_window     = '0;
    apply_setting(setting);
    push_run(SNS_BOTH, 2);
    push_run(SNS_NONE, 2);
    push_run(SNS_RIGHT, 2);
    wait_idle();

    // zero debounce, widest window
    setting.debounce_ticks     = 4'd0;
    setting.base_speed         = '0;
    setting.turn_forward_speed = '1;
    setting.turn_reverse_speed = 7'd101;
    setting.startup_window     = '1;
    apply_setting(setting);
    push_run(SNS_RIGHT, 2);
    push_run(SNS_BOTH, 2);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       setting.debounce_ticks = 4'd15;
        1:       setting.debounce_ticks = 4'd0;
        default: setting.debounce_ticks = DEB_W'($urandom_range(0, 15));
      endcase
      setting.base_speed         = pick_speed();
      setting.turn_forward_speed = pick_speed();
      setting.turn_reverse_speed = pick_speed();
      case ($urandom_range(0, 3))
        0:       setting.startup_window = '0;
        1:       setting.startup_window = TICK_W'(tick_count + $urandom_range(10, 80));
        2:       setting.startup_window = '1;
        default: setting.startup_window = TICK_W'($urandom_range(0, 65535));
      endcase
      apply_setting(setting);
      if (phase == 2) begin
        idle_on   = 1'b0;
        holds_req = holds_req + 1;
        random_ticks(40);
        wait_idle();
        idle_on = 1'b1;
      end
      if (phase == 4) idle_on = 1'b0;
      random_ticks(90);
      if (phase == 3) begin
        wait_idle();
        random_ticks(40);
      end
      wait_idle();
      idle_on = 1'b1;
    end

    // back-to-back ticks, then with gaps
    setting.debounce_ticks     = 4'd2;
    setting.base_speed         = 7'd55;
    setting.turn_forward_speed = 7'd77;
    setting.turn_reverse_speed = 7'd33;
    setting.startup_window     = '1;
    apply_setting(setting);
    idle_on = 1'b0;
    random_ticks(40);
    wait_idle();
    idle_on = 1'b1;
    random_ticks(40);
    wait_idle();

    $display("Checked %0d drive beats under %0d register settings: %0d applied, %0d stops.",
             beats_checked, settings_count, applied_count, station_count);
    $display("Elapsed ticks reached %0d; long result stall and sender drain pauses included.",
             tick_count);
    if (mismatch_count == 0 && stray_count == 0 && expected_drive.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d unexpected beats, %0d missing beats",
               mismatch_count, stray_count, expected_drive.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== debounced_line_follow_steering.f =====
rtl/dlfs_pkg.sv
rtl/dlfs_in_if.sv
rtl/dlfs_out_if.sv
rtl/dlfs_steer.sv
rtl/debounced_line_follow_steering.sv
verif/tb_debounced_line_follow_steering.sv
